// ===== src/usf_pkg.sv =====
package usf_pkg;

	localparam int POSITION_BITS_DEFAULT = 16;
	localparam int OUT_POS_W             = 16;
	localparam int QUEUE_DEPTH           = 2;

	// separator progress through "://"
	typedef enum logic [1:0] {
		SEP_NONE  = 2'd0,
		SEP_COLON = 2'd1,
		SEP_SLASH = 2'd2,
		SEP_FULL  = 2'd3
	} sep_stage_t;

	// classified byte handed from front to back
	typedef struct packed {
		logic letter;
		logic url_char;
		logic colon;
		logic slash;
		logic last;
	} byte_class_t;

	function automatic logic is_letter(input logic [7:0] c);
		is_letter = (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
	endfunction

	function automatic logic is_url_char(input logic [7:0] c);
		logic punct;
		punct = 1'b0;
		case (c)
			"~", ";", "?", ":", "@", "=", "&", "$", "-", "_",
			".", "+", "!", "*", "'", "(", ")", ",", "/": punct = 1'b1;
			default: punct = 1'b0;
		endcase
		is_url_char = is_letter(c) || (c >= "0" && c <= "9") || punct;
	endfunction

endpackage

// ===== src/usf_front.sv =====
module usf_front
	import usf_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        text_valid,
	output logic        text_stall,
	input  logic [7:0]  text_byte,
	input  logic        text_last,
	output logic        push,
	output byte_class_t push_class,
	input  logic        queue_full
);

	logic        valid_s1;
	byte_class_t class_s1;
	logic        advance;

	assign push       = valid_s1 && !queue_full;
	assign push_class = class_s1;
	assign text_stall = valid_s1 && queue_full;
	assign advance    = text_valid && !text_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= 1'b1;
		end else if (push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			class_s1.letter   <= is_letter(text_byte);
			class_s1.url_char <= is_url_char(text_byte);
			class_s1.colon    <= (text_byte == ":");
			class_s1.slash    <= (text_byte == "/");
			class_s1.last     <= text_last;
		end
	end

endmodule

// ===== src/usf_queue.sv =====
module usf_queue
	import usf_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  byte_class_t push_class,
	output logic        full,
	input  logic        pop,
	output logic        nonempty,
	output byte_class_t head_class
);

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	byte_class_t       mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  count_q;

	assign full       = (count_q == CNT_W'(QUEUE_DEPTH));
	assign nonempty   = (count_q != '0);
	assign head_class = mem_q[rd_ptr_q];

	function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
		ptr_inc = (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= ptr_inc(wr_ptr_q);
			if (pop)  rd_ptr_q <= ptr_inc(rd_ptr_q);
			if (push && !pop)      count_q <= count_q + 1'b1;
			else if (pop && !push) count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= push_class;
	end

endmodule

// ===== src/usf_back.sv =====
module usf_back
	import usf_pkg::*;
#(
	parameter int POSITION_BITS = POSITION_BITS_DEFAULT
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 nonempty,
	input  byte_class_t          head_class,
	output logic                 pop,
	output logic                 span_valid,
	input  logic                 span_stall,
	output logic                 url_found,
	output logic [OUT_POS_W-1:0] url_start,
	output logic [OUT_POS_W-1:0] url_stop,
	output logic                 text_done
);

	localparam int P = POSITION_BITS;

	logic [P-1:0] pos_q, run_start_q, cand_start_q;
	logic         run_live_q, cand_scheme_q, inside_q;
	sep_stage_t   sep_q;

	logic [P-1:0] pos_d, run_start_d, cand_start_d, pos_inc, start_c, stop_c;
	logic         run_live_d, cand_scheme_d, inside_d, found_c, emit;
	sep_stage_t   sep_d;

	logic                 out_valid_q, found_q, done_q;
	logic [OUT_POS_W-1:0] start_q, stop_q;

	assign pop     = nonempty && (!out_valid_q || !span_stall);
	assign pos_inc = (pos_q == {P{1'b1}}) ? pos_q : pos_q + 1'b1;

	always_comb begin
		pos_d         = pos_inc;
		run_start_d   = run_start_q;
		run_live_d    = run_live_q;
		cand_start_d  = cand_start_q;
		cand_scheme_d = cand_scheme_q;
		inside_d      = inside_q;
		sep_d         = sep_q;
		found_c       = 1'b0;
		start_c       = '0;
		stop_c        = '0;
		if (inside_q) begin
			if (head_class.url_char) begin
				if (head_class.last) begin
					found_c = 1'b1;
					start_c = cand_start_q;
					stop_c  = pos_inc;
				end
			end else begin
				found_c  = 1'b1;
				start_c  = cand_start_q;
				stop_c   = pos_q;
				inside_d = 1'b0;
			end
			sep_d      = SEP_NONE;
			run_live_d = 1'b0;
		end else if (sep_q == SEP_FULL && cand_scheme_q && head_class.url_char) begin
			inside_d   = 1'b1;
			sep_d      = SEP_NONE;
			run_live_d = 1'b0;
			if (head_class.last) begin
				found_c = 1'b1;
				start_c = cand_start_q;
				stop_c  = pos_inc;
			end
		end else begin
			if (head_class.colon) begin
				sep_d         = SEP_COLON;
				cand_start_d  = run_start_q;
				cand_scheme_d = run_live_q;
			end else if (head_class.slash && sep_q == SEP_COLON) begin
				sep_d = SEP_SLASH;
			end else if (head_class.slash && sep_q == SEP_SLASH) begin
				sep_d = SEP_FULL;
			end else begin
				sep_d = SEP_NONE;
			end
			if (head_class.letter) begin
				if (!run_live_q) begin
					run_start_d = pos_q;
					run_live_d  = 1'b1;
				end
			end else begin
				run_live_d = 1'b0;
			end
		end
		emit = found_c || head_class.last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q         <= '0;
			run_start_q   <= '0;
			run_live_q    <= 1'b0;
			cand_start_q  <= '0;
			cand_scheme_q <= 1'b0;
			inside_q      <= 1'b0;
			sep_q         <= SEP_NONE;
			out_valid_q   <= 1'b0;
		end else begin
			if (pop) begin
				if (head_class.last) begin
					pos_q         <= '0;
					run_start_q   <= '0;
					run_live_q    <= 1'b0;
					cand_start_q  <= '0;
					cand_scheme_q <= 1'b0;
					inside_q      <= 1'b0;
					sep_q         <= SEP_NONE;
				end else begin
					pos_q         <= pos_d;
					run_start_q   <= run_start_d;
					run_live_q    <= run_live_d;
					cand_start_q  <= cand_start_d;
					cand_scheme_q <= cand_scheme_d;
					inside_q      <= inside_d;
					sep_q         <= sep_d;
				end
				out_valid_q <= emit;
			end else if (!span_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && emit) begin
			found_q <= found_c;
			start_q <= OUT_POS_W'(start_c);
			stop_q  <= OUT_POS_W'(stop_c);
			done_q  <= head_class.last;
		end
	end

	assign span_valid = out_valid_q;
	assign url_found  = found_q;
	assign url_start  = start_q;
	assign url_stop   = stop_q;
	assign text_done  = done_q;

endmodule

// ===== src/url_span_finder_core.sv =====
// url_span_finder_core: streaming URL span finder.
// Text channel (text_valid/text_stall): one byte per request, text_last on
// the final byte of a text. A URL is a run of letters, "://", then one or
// more URL characters (letters, digits, '/' and ~;?:@=&$-_.+!*'(),).
// Span channel (span_valid/span_stall): one request per URL found, with
// url_start at the first scheme letter and url_stop just past the URL.
// The final byte of a text always yields a request with text_done set;
// it also carries the span when a URL ends there. Other requests have
// url_found set; url_start/url_stop read zero when url_found is clear.
// Positions saturate at 2^POSITION_BITS-1; ports carry the low 16 bits.
// A byte that closes a URL passes the classify register, the queue and the
// output register before its request shows.
// Throughput: one byte per cycle while the span output is not stalled, set by
// the state update in the back end; a stalled span output holds the back end
// while the 2-entry queue and classify stage keep taking bytes until they fill.
// Reset (arst_n low) empties the pipeline and returns the scan to the start
// of a text at position zero.
module url_span_finder_core
	import usf_pkg::*;
#(
	parameter int POSITION_BITS = POSITION_BITS_DEFAULT
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 text_valid,
	output logic                 text_stall,
	input  logic [7:0]           text_byte,
	input  logic                 text_last,
	output logic                 span_valid,
	input  logic                 span_stall,
	output logic                 url_found,
	output logic [OUT_POS_W-1:0] url_start,
	output logic [OUT_POS_W-1:0] url_stop,
	output logic                 text_done
);

	// front -> queue
	logic        push;
	byte_class_t push_class;
	logic        queue_full;

	// queue -> back
	logic        pop;
	logic        nonempty;
	byte_class_t head_class;

	// Front: accept the byte and reduce it to its character classes.
	usf_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.text_valid (text_valid),
		.text_stall (text_stall),
		.text_byte  (text_byte),
		.text_last  (text_last),
		.push       (push),
		.push_class (push_class),
		.queue_full (queue_full)
	);

	// Short queue so a stalled output does not immediately stall the input.
	usf_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_class (push_class),
		.full       (queue_full),
		.pop        (pop),
		.nonempty   (nonempty),
		.head_class (head_class)
	);

	// Back: scanner state machine and registered span output.
	usf_back #(
		.POSITION_BITS (POSITION_BITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.nonempty   (nonempty),
		.head_class (head_class),
		.pop        (pop),
		.span_valid (span_valid),
		.span_stall (span_stall),
		.url_found  (url_found),
		.url_start  (url_start),
		.url_stop   (url_stop),
		.text_done  (text_done)
	);

endmodule

// ===== src/usf_checker.sv =====
module usf_checker
	import usf_pkg::*;
(
	input logic                 clk,
	input logic                 arst_n,
	input logic                 text_valid,
	input logic                 text_stall,
	input logic [7:0]           text_byte,
	input logic                 text_last,
	input logic                 span_valid,
	input logic                 span_stall,
	input logic                 url_found,
	input logic [OUT_POS_W-1:0] url_start,
	input logic [OUT_POS_W-1:0] url_stop,
	input logic                 text_done
);

	// stalled span request stays up
	a_span_hold: assert property (@(posedge clk) disable iff (!arst_n)
		span_valid && span_stall |=> span_valid)
		else $error("span request dropped under stall");

	// stalled span payload holds
	a_span_stable: assert property (@(posedge clk) disable iff (!arst_n)
		span_valid && span_stall |=> $stable(url_found) && $stable(url_start)
			&& $stable(url_stop) && $stable(text_done))
		else $error("span payload changed under stall");

	// a request without a URL only closes a text
	a_nourl_done: assert property (@(posedge clk) disable iff (!arst_n)
		span_valid && !url_found |-> text_done)
		else $error("empty span request without text_done");

	// no URL means zero positions
	a_nourl_zero: assert property (@(posedge clk) disable iff (!arst_n)
		span_valid && !url_found |-> url_start == '0 && url_stop == '0)
		else $error("nonzero positions without URL");

endmodule

bind url_span_finder_core usf_checker u_usf_checker (.*);

// ===== bench/url_span_checker.sv =====
module url_span_checker
	import usf_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 text_valid,
	input  logic                 text_stall,
	input  logic [7:0]           text_byte,
	input  logic                 text_last,
	input  logic                 span_valid,
	input  logic                 span_stall,
	input  logic                 url_found,
	input  logic [OUT_POS_W-1:0] url_start,
	input  logic [OUT_POS_W-1:0] url_stop,
	input  logic                 text_done,
	output int                   fail_count,
	output int                   pending
);

	localparam int POS_W = POSITION_BITS_DEFAULT;

	typedef struct packed {
		logic                 found;
		logic [OUT_POS_W-1:0] start;
		logic [OUT_POS_W-1:0] stop;
		logic                 done;
	} span_t;

	// scan state
	logic [POS_W-1:0] pos;
	logic [POS_W-1:0] run_start;
	logic             run_live;
	sep_stage_t       sep;
	logic [POS_W-1:0] cand_start;
	logic             cand_scheme;
	logic             in_url;

	span_t span_q[$];
	int    errs;

	function automatic logic letter_byte(input logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
	endfunction

	function automatic logic url_byte(input logic [7:0] c);
		string marks = "~;?:@=&$-_.+!*'(),/";
		logic  hit;
		hit = letter_byte(c) || (c >= "0" && c <= "9");
		for (int k = 0; k < marks.len(); k++)
			if (marks[k] == c)
				hit = 1'b1;
		return hit;
	endfunction

	// position counter saturates at all ones
	function automatic logic [POS_W-1:0] bump(input logic [POS_W-1:0] p);
		return (p == {POS_W{1'b1}}) ? p : p + 1'b1;
	endfunction

	task automatic clear_scan();
		pos         = '0;
		run_start   = '0;
		run_live    = 1'b0;
		sep         = SEP_NONE;
		cand_start  = '0;
		cand_scheme = 1'b0;
		in_url      = 1'b0;
	endtask

	task automatic take_byte(input logic [7:0] c, input logic fin);
		span_t            res;
		logic             urlc;
		logic             hit;
		logic [POS_W-1:0] here;
		res  = '0;
		hit  = 1'b0;
		here = pos;
		urlc = url_byte(c);
		if (in_url) begin
			if (!urlc) begin
				hit       = 1'b1;
				res.start = cand_start[OUT_POS_W-1:0];
				res.stop  = here[OUT_POS_W-1:0];
				in_url    = 1'b0;
			end else if (fin) begin
				hit       = 1'b1;
				res.start = cand_start[OUT_POS_W-1:0];
				res.stop  = bump(here);
			end
			sep      = SEP_NONE;
			run_live = 1'b0;
		end else if (sep == SEP_FULL && cand_scheme && urlc) begin
			in_url   = 1'b1;
			sep      = SEP_NONE;
			run_live = 1'b0;
			if (fin) begin
				hit       = 1'b1;
				res.start = cand_start[OUT_POS_W-1:0];
				res.stop  = bump(here);
			end
		end else begin
			if (c == ":") begin
				sep         = SEP_COLON;
				cand_start  = run_start;
				cand_scheme = run_live;
			end else if (c == "/" && sep == SEP_COLON) begin
				sep = SEP_SLASH;
			end else if (c == "/" && sep == SEP_SLASH) begin
				sep = SEP_FULL;
			end else begin
				sep = SEP_NONE;
			end
			if (!letter_byte(c)) begin
				run_live = 1'b0;
			end else if (!run_live) begin
				run_start = here;
				run_live  = 1'b1;
			end
		end
		pos = bump(here);
		if (hit || fin) begin
			res.found = hit;
			res.done  = fin;
			span_q.insert(span_q.size(), res);
		end
		if (fin)
			clear_scan();
	endtask

	task automatic report(input string field, input int want, input int got);
		$display("%0t: %s expected %0d actual %0d", $time, field, want, got);
		errs++;
	endtask

	task automatic check_span();
		span_t want;
		if (span_q.size() == 0) begin
			$display("%0t: unexpected request found=%0d start=%0d stop=%0d done=%0d",
				$time, url_found, url_start, url_stop, text_done);
			errs++;
		end else begin
			want = span_q.pop_front();
			if (url_found !== want.found)
				report("url_found", want.found, url_found);
			if (url_start !== want.start)
				report("url_start", want.start, url_start);
			if (url_stop !== want.stop)
				report("url_stop", want.stop, url_stop);
			if (text_done !== want.done)
				report("text_done", want.done, text_done);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_scan();
			span_q.delete();
			errs = 0;
			fail_count <= 0;
			pending    <= 0;
		end else begin
			if (text_valid && !text_stall)
				take_byte(text_byte, text_last);
			if (span_valid && !span_stall)
				check_span();
			fail_count <= errs;
			pending    <= span_q.size();
		end
	end

endmodule

// ===== bench/url_span_finder_core_tb.sv =====
module url_span_finder_core_tb;
	import usf_pkg::*;

	// no request taken on either channel for this many cycles -> hung
	localparam int QUIET_LIMIT = 5000;
	// long receiver hold-off used to back the pipeline up into the text input
	localparam int LONG_HOLD   = 300;
	// settle time after the last expected request
	localparam int DRAIN       = 20;
	localparam int PHASE_ITEMS = 270;

	localparam string LETTERS = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ";
	localparam string URLSET  =
		"abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789~;?:@=&$-_.+!*'(),/";
	// printable bytes that end a URL
	localparam string STOPS   = " \"<>[]{}|\\^#%";

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 text_valid;
	logic                 text_stall;
	logic [7:0]           text_byte;
	logic                 text_last;
	logic                 span_valid;
	logic                 span_stall;
	logic                 url_found;
	logic [OUT_POS_W-1:0] url_start;
	logic [OUT_POS_W-1:0] url_stop;
	logic                 text_done;

	int fail_count;
	int pending;

	// idle odds in percent, changed per phase by the stimulus process
	int   send_idle_pct = 16;
	int   recv_idle_pct = 61;
	logic long_hold = 1'b0;
	logic hold_done = 1'b0;

	int         bytes_sent = 0;
	logic [7:0] text_q[$];

	always #4 clk = ~clk;

	url_span_finder_core i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.text_valid(text_valid),
		.text_stall(text_stall),
		.text_byte (text_byte),
		.text_last (text_last),
		.span_valid(span_valid),
		.span_stall(span_stall),
		.url_found (url_found),
		.url_start (url_start),
		.url_stop  (url_stop),
		.text_done (text_done)
	);

	url_span_checker i_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.text_valid(text_valid),
		.text_stall(text_stall),
		.text_byte (text_byte),
		.text_last (text_last),
		.span_valid(span_valid),
		.span_stall(span_stall),
		.url_found (url_found),
		.url_start (url_start),
		.url_stop  (url_stop),
		.text_done (text_done),
		.fail_count(fail_count),
		.pending   (pending)
	);

	function automatic logic [7:0] pick(input string set);
		return set[$urandom_range(set.len() - 1)];
	endfunction

	// byte that is not a URL character: printable, control or high half
	function automatic logic [7:0] stop_byte();
		case ($urandom_range(2))
			0:       return pick(STOPS);
			1:       return 8'($urandom_range(31));
			default: return 8'($urandom_range(255, 128));
		endcase
	endfunction

	task automatic add_byte(input logic [7:0] b);
		text_q.insert(text_q.size(), b);
	endtask

	task automatic add_str(input string s);
		for (int i = 0; i < s.len(); i++)
			add_byte(s[i]);
	endtask

	task automatic add_pick(input string set, input int lo, input int hi);
		int n;
		n = $urandom_range(hi, lo);
		repeat (n)
			add_byte(pick(set));
	endtask

	// One request on the text channel. Valid goes up at the falling edge
	// (maybe after some idle cycles) and the payload holds until accepted.
	task automatic send_byte(input logic [7:0] b, input logic fin);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			text_valid <= 1'b0;
			@(negedge clk);
		end
		text_valid <= 1'b1;
		text_byte  <= b;
		text_last  <= fin;
		@(posedge clk);
		while (text_stall)
			@(posedge clk);
		bytes_sent++;
	endtask

	// ship text_q as one text, last flag on its final byte
	task automatic send_text();
		foreach (text_q[i])
			send_byte(text_q[i], i == text_q.size() - 1);
	endtask

	task automatic send_str(input string s);
		text_q.delete();
		add_str(s);
		send_text();
	endtask

	// Random text made of segments. Most segments are proper URLs with
	// random scheme and body; the rest are noise, broken separators,
	// separators without a scheme and loose URL characters.
	task automatic build_text();
		int segs;
		text_q.delete();
		segs = $urandom_range(5, 1);
		repeat (segs) begin
			case ($urandom_range(9))
				0, 1, 2, 3, 4, 5: begin
					add_pick(LETTERS, 1, 4);
					add_str("://");
					add_pick(URLSET, 1, 8);
					if ($urandom_range(1))
						add_byte(stop_byte());
				end
				6: begin
					repeat ($urandom_range(4, 1))
						add_byte(8'($urandom_range(255)));
				end
				7: begin
					add_pick(LETTERS, 1, 3);
					case ($urandom_range(3))
						0:       add_str(":");
						1:       add_str(":/");
						2:       add_str(":/x");
						default: add_str("//");
					endcase
					add_pick(URLSET, 0, 3);
				end
				8: begin
					add_byte($urandom_range(1) ? stop_byte() : pick("0123456789"));
					add_str("://");
					add_pick(URLSET, 1, 3);
				end
				default: add_pick(URLSET, 1, 4);
			endcase
		end
	endtask

	task automatic run_random(input int count);
		int goal;
		goal = bytes_sent + count;
		while (bytes_sent < goal) begin
			build_text();
			send_text();
		end
	endtask

	// Receiver: random stall per cycle, or once a long counted hold-off so
	// that the queue fills and the block pushes back on the text side.
	initial begin : span_sink
		span_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (long_hold && !hold_done) begin
				span_stall <= 1'b1;
				repeat (LONG_HOLD)
					@(negedge clk);
				hold_done = 1'b1;
			end else begin
				span_stall <= ($urandom_range(99) < recv_idle_pct);
			end
		end
	end

	// Watchdog: too long with no request taken on either channel.
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((text_valid && !text_stall) || (span_valid && !span_stall))
				quiet = 0;
			else
				quiet++;
		end
		$display("FAILURE");
		$finish;
	end

	initial begin : stimulus
		text_valid = 1'b0;
		text_byte  = 8'h00;
		text_last  = 1'b0;
		arst_n     = 1'b0;
		repeat (10)
			@(negedge clk);
		arst_n = 1'b1;

		// Phase 1: sender idles rarely, receiver often.
		// URL right at the start of a text, running to its end.
		send_str("a://b");
		// Separator with no letters in front: only the done request.
		// Opens with byte 0x00 and closes with 0xFF.
		text_q.delete();
		add_byte(8'h00);
		add_str("://z");
		add_byte(8'hFF);
		send_text();
		// Separator as the final bytes of the text: no URL.
		send_str("Zb://");
		// URL closed by the final byte: span and done in one request.
		send_str("x://y ");
		run_random(PHASE_ITEMS);

		// Phase 2: roles swapped.
		send_idle_pct = 61;
		recv_idle_pct = 16;
		run_random(PHASE_ITEMS);

		// Phase 3: no idling, plus one long hold-off on the span side.
		send_idle_pct = 0;
		recv_idle_pct = 0;
		long_hold     = 1'b1;
		run_random(PHASE_ITEMS);

		@(negedge clk);
		text_valid <= 1'b0;

		while (pending != 0)
			@(posedge clk);
		repeat (DRAIN)
			@(posedge clk);
		if (fail_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
